### design/rcf_pkg.sv
// shared types and constants for the rgb convolution filter
`timescale 1ns / 1ps
`default_nettype none
package rcf_pkg;

  localparam int CNT_W = 24;
  localparam int STRIDE_W = 12;
  localparam int ROWS_W = 12;
  localparam int KSIZE_W = 3;
  localparam int DIVISOR_W = 16;
  localparam int COEF_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CHANNEL_MAX = 255;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 12'd3072;
  localparam logic [ROWS_W-1:0] ROWS_RST = 12'd480;
  localparam logic [KSIZE_W-1:0] KSIZE_RST = 3'd3;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 16'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd3;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD,
    ST_BORDER,
    ST_PASS,
    ST_MAC,
    ST_DRAIN,
    ST_SIGN,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### design/rcf_div.sv
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rcf_div #(
  parameter int NW = 30,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot,
  output logic [DW-1:0]      rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  always_comb begin
    rem_sh = {rem_r, num_r[NW-1]};
    diff = rem_sh - {1'b0, den_r};
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

### design/rcf_ring.sv
// line buffer ring of image bytes, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module rcf_ring #(
  parameter int DEPTH = 18453,
  parameter int AW = 15
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### design/rgb_convolution_filter.sv
// top level: sequencer, coefficient store and shared multiply-accumulate
// an eligible image byte or flush word is worked through the serial divider
// (used for the column position and the final division) and the single
// multiply-accumulate walking the kernel taps
// border bytes and coefficient loads finish sooner; one word in flight at a time
// synchronous active-low reset clears counters, config and coefficients
// no clearing pass: the byte ring is unreset storage
`timescale 1ns / 1ps
`default_nettype none
module rgb_convolution_filter
  import rcf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 3072,
  parameter int MAX_KERNEL = 7,
  parameter int CHANNELS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,  // coef_index, coef_value, pixel_byte, zero pad
  input  wire logic [1:0]            in_tuser,  // func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata, // filtered_byte
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_ROW_BYTES * (MAX_KERNEL - 1) + MAX_KERNEL * CHANNELS;
  localparam int RA_W = $clog2(DEPTH);
  localparam int COEFS = MAX_KERNEL * MAX_KERNEL;
  localparam int CI_W = (COEFS > 1) ? $clog2(COEFS) : 1;
  localparam int HMAX = (MAX_KERNEL - 1) / 2;
  localparam int OFF_W = 17;
  localparam int SUM_W = ((RA_W > OFF_W) ? RA_W : OFF_W) + 2;
  localparam int ACC_W = BYTE_W + COEF_W + CI_W + 2;
  localparam int NW = (ACC_W - 1 > CNT_W) ? ACC_W - 1 : CNT_W;
  localparam int PROD_W = BYTE_W + 1 + COEF_W;

  // config registers
  logic [STRIDE_W-1:0]  stride_r;
  logic [ROWS_W-1:0]    rows_r;
  logic [KSIZE_W-1:0]   ksize_r;
  logic [DIVISOR_W-1:0] divisor_r;

  // effective settings
  logic [STRIDE_W-1:0]  s_eff;
  logic [ROWS_W-1:0]    rows_eff;
  logic [1:0]           h_eff;
  logic [DIVISOR_W-1:0] d_eff;
  logic [CNT_W-1:0]     n_frame;
  logic [CNT_W-1:0]     hs;
  logic [CNT_W-1:0]     hc;
  logic [3:0]           kw;
  logic [CI_W:0]        taps;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] recv_r, recv_nxt;
  logic [CNT_W-1:0] em_r, em_nxt;
  logic [RA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RA_W-1:0]  base_r, base_nxt;
  logic [CI_W-1:0]  k_r, k_nxt;
  logic [3:0]       j_r, j_nxt;
  logic signed [OFF_W-1:0] off_r, off_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic             mac_v_r, mac_v_nxt;
  logic [7:0]       res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  func_t            in_func;
  logic [5:0]       in_idx;
  logic [COEF_W-1:0] in_coef;
  logic [7:0]       in_byte;
  logic             do_clear;
  logic [CNT_W-1:0] recv_eff;
  logic [RA_W-1:0]  wr_ptr_eff;
  logic             ring_wr;
  logic [CNT_W:0]   need;
  logic             eligible;
  logic             border;
  logic [STRIDE_W-1:0] col;
  logic             out_free;
  logic             last_tap;

  // coefficient store
  logic [COEF_W-1:0] coef_mem [COEFS];
  logic [COEFS-1:0]  coef_vld_r;
  logic [COEF_W-1:0] coef_rd_r;
  logic              coef_vld_q_r;
  logic              coef_wr;
  logic              coef_rd;

  // ring
  logic              ring_rd;
  logic [RA_W-1:0]   ring_rd_addr;
  logic [7:0]        ring_rd_data;
  logic signed [SUM_W-1:0] addr_sum;

  // divider
  logic              div_start;
  logic [NW-1:0]     div_num;
  logic [DIVISOR_W-1:0] div_den;
  logic              div_done;
  logic [NW-1:0]     div_quot;
  logic [DIVISOR_W-1:0] div_rem;

  logic signed [PROD_W-1:0] prod;
  logic signed [COEF_W-1:0] coef_q;

  assign cfg_ready = 1'b1;
  assign in_func = func_t'(in_tuser);
  assign in_idx = in_tdata[5:0];
  assign in_coef = in_tdata[21:6];
  assign in_byte = in_tdata[29:22];
  assign in_acc = in_tvalid && in_tready;

  // effective configuration
  always_comb begin
    if (32'(stride_r) > MAX_ROW_BYTES) begin
      s_eff = STRIDE_W'(MAX_ROW_BYTES);
    end else if (stride_r == '0) begin
      s_eff = STRIDE_W'(1);
    end else begin
      s_eff = stride_r;
    end
    rows_eff = (rows_r == '0) ? ROWS_W'(1) : rows_r;
    h_eff = (32'(ksize_r[2:1]) > HMAX) ? 2'(HMAX) : ksize_r[2:1];
    d_eff = (divisor_r == '0) ? DIVISOR_W'(1) : divisor_r;
    n_frame = CNT_W'(s_eff) * CNT_W'(rows_eff);
    hs = CNT_W'(h_eff) * CNT_W'(s_eff);
    hc = CNT_W'(h_eff) * CNT_W'(CHANNELS);
    kw = {1'b0, h_eff, 1'b1};
    taps = (CI_W + 1)'(kw * kw);
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RST;
      rows_r <= ROWS_RST;
      ksize_r <= KSIZE_RST;
      divisor_r <= DIVISOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_STRIDE:  stride_r <= cfg_data[STRIDE_W-1:0];
        CFG_FRAME_ROWS:  rows_r <= cfg_data[ROWS_W-1:0];
        CFG_KERNEL_SIZE: ksize_r <= cfg_data[KSIZE_W-1:0];
        CFG_DIVISOR:     divisor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_BYTE || in_func == FUNC_FLUSH)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:  state_nxt = eligible ? ST_MOD : ST_IDLE;
      ST_MOD:    if (div_done) state_nxt = ST_BORDER;
      ST_BORDER: state_nxt = border ? ST_PASS : ST_MAC;
      ST_PASS:   state_nxt = ST_OUT;
      ST_MAC:    if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_SIGN;
      ST_SIGN:   state_nxt = acc_r[ACC_W-1] ? ST_OUT : ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    coef_wr = 1'b0;
    div_start = 1'b0;
    div_num = NW'(acc_r[ACC_W-2:0]);
    div_den = d_eff;
    ring_rd = 1'b0;
    coef_rd = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        coef_wr = in_tvalid && (in_func == FUNC_LOAD) && (32'(in_idx) < COEFS);
      end
      ST_CHECK: begin
        div_start = eligible;
        div_num = NW'(em_r);
        div_den = DIVISOR_W'(s_eff);
      end
      ST_BORDER: ring_rd = border;
      ST_MAC: begin
        ring_rd = 1'b1;
        coef_rd = 1'b1;
      end
      ST_SIGN: div_start = !acc_r[ACC_W-1];
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;
  assign col = div_rem[STRIDE_W-1:0];
  assign last_tap = ((CI_W + 1)'(k_r) == taps - 1'b1);

  always_comb begin
    do_clear = (em_r >= n_frame);
    recv_eff = do_clear ? '0 : recv_r;
    wr_ptr_eff = do_clear ? '0 : wr_ptr_r;
    ring_wr = in_acc && (in_func == FUNC_BYTE) && (recv_eff < n_frame);
    need = (CNT_W + 1)'(em_r) + (CNT_W + 1)'(hs) + (CNT_W + 1)'(hc) + 1'b1;
    if (need > (CNT_W + 1)'(n_frame)) begin
      need = (CNT_W + 1)'(n_frame);
    end
    eligible = (em_r < recv_r) && ((CNT_W + 1)'(recv_r) >= need);
    border = (CNT_W'(col) < hc) || (CNT_W'(col) + hc >= CNT_W'(s_eff)) ||
             (em_r < hs) || (n_frame - em_r < hs);
  end

  // ring read address: window tap relative to the byte being produced
  always_comb begin
    addr_sum = SUM_W'(base_r) + SUM_W'(off_r);
    if (addr_sum < 0) begin
      addr_sum = addr_sum + SUM_W'(DEPTH);
    end else if (addr_sum >= SUM_W'(DEPTH)) begin
      addr_sum = addr_sum - SUM_W'(DEPTH);
    end
    ring_rd_addr = (state_r == ST_MAC) ? addr_sum[RA_W-1:0] : base_r;
  end

  assign coef_q = coef_vld_q_r ? $signed(coef_rd_r) : '0;
  assign prod = $signed({1'b0, ring_rd_data}) * coef_q;

  // datapath
  always_comb begin
    recv_nxt = recv_r;
    em_nxt = em_r;
    wr_ptr_nxt = wr_ptr_r;
    base_nxt = base_r;
    k_nxt = k_r;
    j_nxt = j_r;
    off_nxt = off_r;
    acc_nxt = acc_r;
    mac_v_nxt = 1'b0;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (mac_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_BYTE || in_func == FUNC_FLUSH)) begin
          if (do_clear) begin
            em_nxt = '0;
            base_nxt = '0;
          end
          recv_nxt = recv_eff;
          wr_ptr_nxt = wr_ptr_eff;
          if (ring_wr) begin
            recv_nxt = recv_eff + 1'b1;
            wr_ptr_nxt = (32'(wr_ptr_eff) == DEPTH - 1) ? '0 : wr_ptr_eff + 1'b1;
          end
        end
      end
      ST_BORDER: begin
        k_nxt = '0;
        j_nxt = '0;
        off_nxt = -OFF_W'(hs + hc);
        acc_nxt = '0;
      end
      ST_PASS: res_nxt = ring_rd_data;
      ST_MAC: begin
        mac_v_nxt = 1'b1;
        k_nxt = k_r + 1'b1;
        if (j_r == {1'b0, h_eff, 1'b0}) begin
          j_nxt = '0;
          off_nxt = off_r + OFF_W'(s_eff) - OFF_W'(hc + hc);
        end else begin
          j_nxt = j_r + 1'b1;
          off_nxt = off_r + OFF_W'(CHANNELS);
        end
      end
      ST_SIGN: begin
        if (acc_r[ACC_W-1]) begin
          res_nxt = '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt = (div_quot > NW'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : div_quot[7:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          out_last_nxt = (em_r + 1'b1 == n_frame);
          if (em_r + 1'b1 >= n_frame) begin
            em_nxt = '0;
            recv_nxt = '0;
            wr_ptr_nxt = '0;
            base_nxt = '0;
          end else begin
            em_nxt = em_r + 1'b1;
            base_nxt = (32'(base_r) == DEPTH - 1) ? '0 : base_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      recv_r <= '0;
      em_r <= '0;
      wr_ptr_r <= '0;
      base_r <= '0;
      mac_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      coef_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      recv_r <= recv_nxt;
      em_r <= em_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      base_r <= base_nxt;
      mac_v_r <= mac_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (coef_wr) begin
        coef_vld_r[CI_W'(in_idx)] <= 1'b1;
      end
    end
    k_r <= k_nxt;
    j_r <= j_nxt;
    off_r <= off_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // coefficient memory with registered read
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[CI_W'(in_idx)] <= in_coef;
    end
    if (coef_rd) begin
      coef_rd_r <= coef_mem[k_r];
      coef_vld_q_r <= coef_vld_r[k_r];
    end
  end

  rcf_ring #(
    .DEPTH(DEPTH),
    .AW(RA_W)
  ) u_ring (
    .clk(clk),
    .wr_en(ring_wr),
    .wr_addr(wr_ptr_eff),
    .wr_data(in_byte),
    .rd_en(ring_rd),
    .rd_addr(ring_rd_addr),
    .rd_data(ring_rd_data)
  );

  rcf_div #(
    .NW(NW),
    .DW(DIVISOR_W)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quot(div_quot),
    .rem(div_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule
`default_nettype wire
